// ===== hw/rtl/brf_pkg.sv =====
package brf_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int BLOCK_BYTES = 8;

   localparam int LANES    = BLOCK_BYTES;
   localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int ROWS     = (STORE_DEPTH + LANES - 1) / LANES;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FILL_W   = $clog2(STORE_DEPTH);
   localparam int CAPI_W   = FILL_W + 1;
   localparam int CSR_W    = 11;
   localparam int CMP_W    = (CAPI_W > CSR_W) ? CAPI_W + 1 : CSR_W + 1;
   localparam int COUNT_W  = 4;
   localparam int SUM_W    = 5;
   localparam int DATA_W   = 64;

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_POLL = 2'd1;
   localparam logic [1:0] FUNC_SIZE = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [COUNT_W-1:0] byte_count;
      logic [DATA_W-1:0]  write_bytes;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [FILL_W-1:0]  fill_level;
      logic [DATA_W-1:0]  read_bytes;
   } rsp_type;

   // Per-request control shared by every lane.
   typedef struct packed {
      logic               wr;
      logic               rd;
      logic [LANE_W-1:0]  wr_lane;
      logic [ROW_W-1:0]   wr_row;
      logic [LANE_W-1:0]  rd_lane;
      logic [ROW_W-1:0]   rd_row;
      logic [COUNT_W-1:0] count;
   } lane_ctl_type;

   // What the merge stage needs in the cycle after the request.
   typedef struct packed {
      logic               valid;
      logic               ok;
      logic               poll;
      logic [FILL_W-1:0]  fill;
      logic [LANE_W-1:0]  lane;
      logic [COUNT_W-1:0] count;
   } merge_ctl_type;

endpackage

// ===== hw/rtl/brf_ram.sv =====
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/brf_lane.sv =====
module brf_lane
   import brf_pkg::*;
(
   input  logic                clock,
   input  logic [LANE_W-1:0]   lane_id,
   input  lane_ctl_type        ctl,
   input  logic [DATA_W-1:0]   write_bytes,
   output logic [7:0]          rd_byte
);

   logic [LANE_W:0]  wr_off;
   logic [LANE_W:0]  rd_off;
   logic [ROW_W:0]   wr_row_inc;
   logic [ROW_W:0]   rd_row_inc;
   logic [ROW_W-1:0] wr_row;
   logic [ROW_W-1:0] rd_row;
   logic             wr_en;
   logic             rd_en;
   logic [7:0]       wr_byte;

   // Offset of this lane's byte within the block, counted from the base lane.
   always_comb begin
      if (lane_id >= ctl.wr_lane) begin
         wr_off = {1'b0, lane_id} - {1'b0, ctl.wr_lane};
      end else begin
         wr_off = {1'b0, lane_id} + (LANE_W+1)'(LANES) - {1'b0, ctl.wr_lane};
      end
      if (lane_id >= ctl.rd_lane) begin
         rd_off = {1'b0, lane_id} - {1'b0, ctl.rd_lane};
      end else begin
         rd_off = {1'b0, lane_id} + (LANE_W+1)'(LANES) - {1'b0, ctl.rd_lane};
      end
   end

   // Lanes below the base lane fall on the following row.
   always_comb begin
      wr_row_inc = {1'b0, ctl.wr_row} + (ROW_W+1)'(1);
      rd_row_inc = {1'b0, ctl.rd_row} + (ROW_W+1)'(1);
      if (lane_id >= ctl.wr_lane) begin
         wr_row = ctl.wr_row;
      end else if (wr_row_inc == (ROW_W+1)'(ROWS)) begin
         wr_row = '0;
      end else begin
         wr_row = wr_row_inc[ROW_W-1:0];
      end
      if (lane_id >= ctl.rd_lane) begin
         rd_row = ctl.rd_row;
      end else if (rd_row_inc == (ROW_W+1)'(ROWS)) begin
         rd_row = '0;
      end else begin
         rd_row = rd_row_inc[ROW_W-1:0];
      end
   end

   assign wr_en   = ctl.wr && (SUM_W'(wr_off) < SUM_W'(ctl.count));
   assign rd_en   = ctl.rd && (SUM_W'(rd_off) < SUM_W'(ctl.count));
   assign wr_byte = write_bytes[8*wr_off +: 8];

   brf_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
   ) u_bank (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_row),
      .wdata (wr_byte),
      .re    (rd_en),
      .raddr (rd_row),
      .rdata (rd_byte)
   );

endmodule

// ===== hw/rtl/brf_merge.sv =====
module brf_merge
   import brf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  merge_ctl_type ctl,
   input  logic [7:0]    lane_bytes [LANES],
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Rotate the bank outputs back into block order and zero the unused bytes.
   always_comb begin
      logic [LANE_W:0] src;
      rsp_in            = '0;
      rsp_in.ok         = ctl.ok;
      rsp_in.fill_level = ctl.fill;
      for (int i = 0; i < LANES; i++) begin
         if (SUM_W'(ctl.lane) + SUM_W'(i) >= SUM_W'(LANES)) begin
            src = (LANE_W+1)'(ctl.lane) + (LANE_W+1)'(i) - (LANE_W+1)'(LANES);
         end else begin
            src = (LANE_W+1)'(ctl.lane) + (LANE_W+1)'(i);
         end
         if (ctl.poll && (SUM_W'(i) < SUM_W'(ctl.count))) begin
            rsp_in.read_bytes[8*i +: 8] = lane_bytes[src[LANE_W-1:0]];
         end
      end
   end

   assign valid_in = ctl.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/byte_ring_fifo_block_access.sv =====
// Circular byte FIFO with all-or-nothing block add and poll.
//
// A request (add, poll or size query) is taken at a rising edge with start
// high; busy is never raised, so a new request may be issued every cycle.
// Each request yields exactly one word on rsp_data, marked by rsp_valid for
// one cycle, in request order. Throughput is one request per cycle: the
// byte store is split into one bank per byte of a block, and every bank
// does at most one write or one read per request. A result passes through
// the registered bank read and the output register after the merge stage
// that puts the bytes back in order.
// The receiver cannot stall; it must take every word in the cycle it shows.
// csr_we writes the ring capacity (clamped to the store size, at least 2)
// and empties the ring; write it only while no request is in flight.
// Reset empties the ring and sets the capacity to the full store. Store
// contents need no clearing since only bytes counted in the fill are read.
module byte_ring_fifo_block_access
   import brf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam logic [CAPI_W-1:0] CAP_RESET =
      (STORE_DEPTH < 1024) ? CAPI_W'(STORE_DEPTH) : CAPI_W'(1024);

   logic [CAPI_W-1:0] cap_ff,     cap_in;
   logic [FILL_W-1:0] fill_ff,    fill_in;
   logic [LANE_W-1:0] wr_lane_ff, wr_lane_in;
   logic [ROW_W-1:0]  wr_row_ff,  wr_row_in;
   logic [LANE_W-1:0] rd_lane_ff, rd_lane_in;
   logic [ROW_W-1:0]  rd_row_ff,  rd_row_in;
   merge_ctl_type     mctl_ff,    mctl_in;

   logic              cnt_ok;
   logic              add_ok;
   logic              poll_ok;
   logic              req_ok;
   logic [CAPI_W:0]   add_total;
   logic [CMP_W-1:0]  csr_ext;
   logic [CAPI_W-1:0] cap_clamped;
   lane_ctl_type      lctl;
   logic [7:0]        lane_bytes [LANES];

   assign busy = 1'b0;

   assign cnt_ok    = SUM_W'(req_data.byte_count) <= SUM_W'(LANES);
   assign add_total = (CAPI_W+1)'(fill_ff) + (CAPI_W+1)'(req_data.byte_count);
   assign add_ok    = start && (req_data.func == FUNC_ADD) && cnt_ok &&
                      (add_total < {1'b0, cap_ff});
   assign poll_ok   = start && (req_data.func == FUNC_POLL) && cnt_ok &&
                      (FILL_W'(req_data.byte_count) <= fill_ff);
   assign req_ok    = add_ok || poll_ok || (req_data.func == FUNC_SIZE);

   assign lctl.wr      = add_ok;
   assign lctl.rd      = poll_ok;
   assign lctl.wr_lane = wr_lane_ff;
   assign lctl.wr_row  = wr_row_ff;
   assign lctl.rd_lane = rd_lane_ff;
   assign lctl.rd_row  = rd_row_ff;
   assign lctl.count   = req_data.byte_count;

   assign csr_ext = CMP_W'(csr_wdata);
   always_comb begin
      if (csr_ext < CMP_W'(2)) begin
         cap_clamped = CAPI_W'(2);
      end else if (csr_ext > CMP_W'(STORE_DEPTH)) begin
         cap_clamped = CAPI_W'(STORE_DEPTH);
      end else begin
         cap_clamped = csr_ext[CAPI_W-1:0];
      end
   end

   // Physical pointers walk lane by lane and row by row; the ring capacity
   // only limits the fill, since no byte is addressed by its ring position.
   always_comb begin
      logic [SUM_W-1:0] wsum;
      logic [SUM_W-1:0] rsum;
      logic [ROW_W:0]   wrow;
      logic [ROW_W:0]   rrow;
      cap_in     = cap_ff;
      fill_in    = fill_ff;
      wr_lane_in = wr_lane_ff;
      wr_row_in  = wr_row_ff;
      rd_lane_in = rd_lane_ff;
      rd_row_in  = rd_row_ff;
      wsum = SUM_W'(wr_lane_ff) + SUM_W'(req_data.byte_count);
      rsum = SUM_W'(rd_lane_ff) + SUM_W'(req_data.byte_count);
      wrow = {1'b0, wr_row_ff} + (ROW_W+1)'(1);
      rrow = {1'b0, rd_row_ff} + (ROW_W+1)'(1);
      if (csr_we) begin
         cap_in     = cap_clamped;
         fill_in    = '0;
         wr_lane_in = '0;
         wr_row_in  = '0;
         rd_lane_in = '0;
         rd_row_in  = '0;
      end else if (add_ok) begin
         fill_in = add_total[FILL_W-1:0];
         if (wsum >= SUM_W'(LANES)) begin
            wr_lane_in = LANE_W'(wsum - SUM_W'(LANES));
            wr_row_in  = (wrow == (ROW_W+1)'(ROWS)) ? '0 : wrow[ROW_W-1:0];
         end else begin
            wr_lane_in = LANE_W'(wsum);
         end
      end else if (poll_ok) begin
         fill_in = fill_ff - FILL_W'(req_data.byte_count);
         if (rsum >= SUM_W'(LANES)) begin
            rd_lane_in = LANE_W'(rsum - SUM_W'(LANES));
            rd_row_in  = (rrow == (ROW_W+1)'(ROWS)) ? '0 : rrow[ROW_W-1:0];
         end else begin
            rd_lane_in = LANE_W'(rsum);
         end
      end
   end

   always_comb begin
      mctl_in.valid = start;
      mctl_in.ok    = req_ok;
      mctl_in.poll  = poll_ok;
      mctl_in.fill  = fill_in;
      mctl_in.lane  = rd_lane_ff;
      mctl_in.count = req_data.byte_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         fill_ff       <= '0;
         wr_lane_ff    <= '0;
         wr_row_ff     <= '0;
         rd_lane_ff    <= '0;
         rd_row_ff     <= '0;
         mctl_ff       <= '0;
      end else begin
         cap_ff        <= cap_in;
         fill_ff       <= fill_in;
         wr_lane_ff    <= wr_lane_in;
         wr_row_ff     <= wr_row_in;
         rd_lane_ff    <= rd_lane_in;
         rd_row_ff     <= rd_row_in;
         mctl_ff       <= mctl_in;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      brf_lane u_lane (
         .clock       (clock),
         .lane_id     (LANE_W'(g)),
         .ctl         (lctl),
         .write_bytes (req_data.write_bytes),
         .rd_byte     (lane_bytes[g])
      );
   end

   brf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mctl_ff),
      .lane_bytes (lane_bytes),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import brf_pkg::*;

   // The package names only three request kinds; the fourth code is refused.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   class fifo_scoreboard;
      logic [7:0]  ring_bytes [STORE_DEPTH];
      int unsigned wr_ptr;
      int unsigned rd_ptr;
      int unsigned ring_len;
      int unsigned mismatches;
      rsp_type     expected_q [$];

      function new();
         wr_ptr     = 0;
         rd_ptr     = 0;
         ring_len   = STORE_DEPTH;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void set_ring_length(logic [CSR_W-1:0] value);
         int unsigned len;
         len = 32'(value);
         if (len < 2) len = 2;
         if (len > STORE_DEPTH) len = STORE_DEPTH;
         ring_len = len;
         wr_ptr   = 0;
         rd_ptr   = 0;
      endfunction

      function int unsigned held();
         return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + ring_len - rd_ptr;
      endfunction

      function int unsigned advance(int unsigned ptr);
         return (ptr + 1 >= ring_len) ? 0 : ptr + 1;
      endfunction

      function void note_request(req_type req);
         rsp_type     want;
         int unsigned fill;
         int unsigned n;
         fill = held();
         n    = 32'(req.byte_count);
         want = '0;
         case (req.func)
            FUNC_ADD: begin
               // One slot always stays empty, so a full ring holds ring_len - 1.
               if (n <= BLOCK_BYTES && fill + n < ring_len) begin
                  for (int i = 0; i < n; i++) begin
                     ring_bytes[wr_ptr] = req.write_bytes[8*i +: 8];
                     wr_ptr = advance(wr_ptr);
                  end
                  want.ok = 1'b1;
               end
            end
            FUNC_POLL: begin
               if (n <= BLOCK_BYTES && n <= fill) begin
                  for (int i = 0; i < n; i++) begin
                     want.read_bytes[8*i +: 8] = ring_bytes[rd_ptr];
                     rd_ptr = advance(rd_ptr);
                  end
                  want.ok = 1'b1;
               end
            end
            FUNC_SIZE: want.ok = 1'b1;
            default: ;
         endcase
         want.fill_level = FILL_W'(held());
         expected_q.push_back(want);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report("unexpected word", got.read_bytes, '0);
         end else begin
            want = expected_q.pop_front();
            if (got.ok !== want.ok) report("ok", 64'(got.ok), 64'(want.ok));
            if (got.fill_level !== want.fill_level)
               report("fill_level", 64'(got.fill_level), 64'(want.fill_level));
            if (got.read_bytes !== want.read_bytes)
               report("read_bytes", got.read_bytes, want.read_bytes);
         end
      endtask
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   fifo_scoreboard ledger = new();
   int unsigned    words_sent = 0;

   byte_ring_fifo_block_access dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200_000;
      $display("FAILED: results differ");
      $finish;
   end

   // A result shown at this edge never belongs to a word taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) ledger.check_result(rsp_data);
         if (csr_we) ledger.set_ring_length(csr_wdata);
         if (start && !busy) ledger.note_request(req_data);
      end
   end

   function automatic req_type make_word(logic [1:0] func, int unsigned count,
                                         logic [63:0] bytes);
      req_type w;
      w.func        = func;
      w.byte_count  = COUNT_W'(count);
      w.write_bytes = bytes;
      return w;
   endfunction

   function automatic req_type random_word(int unsigned add_pct);
      int unsigned pick;
      int unsigned count;
      logic [1:0]  func;
      pick = $urandom_range(99);
      if (pick < add_pct) func = FUNC_ADD;
      else if (pick < 88) func = FUNC_POLL;
      else if (pick < 97) func = FUNC_SIZE;
      else func = FUNC_UNUSED;
      count = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
      return make_word(func, count, {$urandom, $urandom});
   endfunction

   task automatic send(input req_type w);
      // Idle now and then, but not inside one long stretch of back-to-back words.
      if ((words_sent < 150 || words_sent >= 260) && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic load_capacity(input logic [CSR_W-1:0] value);
      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int unsigned ring_sizes [12];
      int unsigned add_bias   [12];
      ring_sizes = '{2, 0, 3, 9, 17, 2047, 300, 1, 1025, 1024, 0, 0};
      add_bias   = '{50, 50, 50, 50, 50, 75, 80, 50, 50, 40, 50, 55};
      ring_sizes[10] = $urandom_range(40, 4);
      ring_sizes[11] = $urandom_range(1024, 2);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset capacity.
      send(make_word(FUNC_SIZE, 0, '0));
      send(make_word(FUNC_POLL, 1, '0));
      send(make_word(FUNC_POLL, 0, '0));
      send(make_word(FUNC_ADD, 0, '1));
      send(make_word(FUNC_ADD, 8, '1));
      send(make_word(FUNC_ADD, 8, '0));
      send(make_word(FUNC_ADD, 9, '1));
      send(make_word(FUNC_ADD, 15, '1));
      send(make_word(FUNC_POLL, 15, '0));
      send(make_word(FUNC_POLL, 9, '0));
      send(make_word(FUNC_UNUSED, 8, '1));
      send(make_word(FUNC_ADD, 1, 64'h0000_0000_0000_00a5));
      send(make_word(FUNC_SIZE, 15, '1));
      send(make_word(FUNC_POLL, 8, '0));
      send(make_word(FUNC_POLL, 3, '1));
      send(make_word(FUNC_POLL, 8, '0));
      send(make_word(FUNC_POLL, 6, '0));
      send(make_word(FUNC_SIZE, 0, '0));
      send(make_word(FUNC_ADD, 8, 64'h0123_4567_89ab_cdef));
      send(make_word(FUNC_POLL, 8, '0));

      // Out-of-range capacities are clamped by the block, which also empties the ring.
      for (int p = 0; p < 12; p++) begin
         load_capacity(CSR_W'(ring_sizes[p]));
         repeat (48) send(random_word(add_bias[p]));
      end

      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
